/* rtl/gmds_pkg.sv */
// Shared types, cell codes and geometry constants for the grid maze solver.
package gmds_pkg;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int NCELLS   = MAX_COLS * MAX_ROWS;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int ADDR_W   = $clog2(NCELLS);
	localparam int SP_W     = $clog2(NCELLS + 1);
	localparam int DIR_W    = 3;
	localparam int STK_W    = ROW_W + COL_W + DIR_W;

	localparam logic [2:0] C_OPEN = 3'd0;
	localparam logic [2:0] C_WALL = 3'd1;
	localparam logic [2:0] C_GOAL = 3'd2;
	localparam logic [2:0] C_DOT  = 3'd3;
	localparam logic [2:0] C_STAR = 3'd4;
	localparam logic [2:0] C_DEAD = 3'd5;

	localparam logic [1:0] FN_WRITE = 2'd0;
	localparam logic [1:0] FN_SOLVE = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;

	localparam logic [1:0] REG_ORDER = 2'd0;
	localparam logic [1:0] REG_COLS  = 2'd1;
	localparam logic [1:0] REG_ROWS  = 2'd2;

	typedef struct packed {
		logic       order;
		logic [6:0] ncols;
		logic [6:0] nrows;
	} cfg_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(32'(r) * MAX_COLS + 32'(c));
	endfunction

endpackage

/* rtl/gmds_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
module gmds_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 3
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/gmds_ctrl.sv */
// Command sequencer and depth-first search engine over the grid and stack memories.
module gmds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic [5:0]          col,
	input  logic [5:0]          row,
	input  logic [2:0]          cell_code,
	input  gmds_pkg::cfg_t      cfg,
	output logic                done,
	output logic                found,
	output logic [2:0]          cell_value
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_STEP  = 3'd3;
	localparam logic [2:0] ST_NB    = 3'd4;
	localparam logic [2:0] ST_POP   = 3'd5;

	localparam logic [1:0] DIR_PX = 2'd0;
	localparam logic [1:0] DIR_PY = 2'd1;
	localparam logic [1:0] DIR_MX = 2'd2;
	localparam logic [1:0] DIR_MY = 2'd3;

	logic [2:0]                   state_q, state_d;
	logic [gmds_pkg::COL_W-1:0]   cur_col_q, cur_col_d, nb_col_q, nb_col_d;
	logic [gmds_pkg::ROW_W-1:0]   cur_row_q, cur_row_d, nb_row_q, nb_row_d;
	logic [gmds_pkg::DIR_W-1:0]   dir_q, dir_d;
	logic [gmds_pkg::SP_W-1:0]    sp_q, sp_d;
	logic                         done_q, done_d, found_q, found_d;
	logic [2:0]                   value_q, value_d;

	logic                         g_we;
	logic [gmds_pkg::ADDR_W-1:0]  g_waddr, g_raddr;
	logic [2:0]                   g_wdata, g_rdata;
	logic                         s_we;
	logic [gmds_pkg::ADDR_W-1:0]  s_waddr, s_raddr;
	logic [gmds_pkg::STK_W-1:0]   s_wdata, s_rdata;

	logic                         in_inside;
	logic [gmds_pkg::COL_W-1:0]   in_col;
	logic [gmds_pkg::ROW_W-1:0]   in_row;
	logic [6:0]                   nc_lim, nr_lim;
	logic [2:0]                   mark;
	logic [1:0]                   dsel;
	logic                         nb_ok;
	logic [gmds_pkg::COL_W-1:0]   nx_col;
	logic [gmds_pkg::ROW_W-1:0]   nx_row;
	logic                         rd_blocked;
	logic [gmds_pkg::SP_W-1:0]    sp_m1, sp_m2;

	gmds_ram #(.DEPTH(gmds_pkg::NCELLS), .WIDTH(3)) u_grid (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	gmds_ram #(.DEPTH(gmds_pkg::NCELLS), .WIDTH(gmds_pkg::STK_W)) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign in_inside = (32'(col) < gmds_pkg::MAX_COLS) && (32'(row) < gmds_pkg::MAX_ROWS);
	assign in_col    = gmds_pkg::COL_W'(col);
	assign in_row    = gmds_pkg::ROW_W'(row);
	assign nc_lim    = (32'(cfg.ncols) > gmds_pkg::MAX_COLS) ? 7'(gmds_pkg::MAX_COLS) : cfg.ncols;
	assign nr_lim    = (32'(cfg.nrows) > gmds_pkg::MAX_ROWS) ? 7'(gmds_pkg::MAX_ROWS) : cfg.nrows;
	assign mark      = cfg.order ? gmds_pkg::C_STAR : gmds_pkg::C_DOT;
	// mode 1 swaps the x and y axes of the mode 0 order
	assign dsel      = dir_q[1:0] ^ {1'b0, cfg.order};
	assign rd_blocked = (g_rdata == gmds_pkg::C_WALL) || (g_rdata == mark) ||
		(g_rdata == gmds_pkg::C_DEAD);
	assign sp_m1     = sp_q - gmds_pkg::SP_W'(1);
	assign sp_m2     = sp_q - gmds_pkg::SP_W'(2);

	always_comb begin
		nb_ok  = 1'b1;
		nx_col = cur_col_q;
		nx_row = cur_row_q;
		case (dsel)
			DIR_PX: begin
				if (32'(cur_col_q) + 32'd1 < 32'(nc_lim)) nx_col = cur_col_q + 1'b1;
				else nb_ok = 1'b0;
			end
			DIR_PY: begin
				if (32'(cur_row_q) + 32'd1 < 32'(nr_lim)) nx_row = cur_row_q + 1'b1;
				else nb_ok = 1'b0;
			end
			DIR_MX: begin
				if (cur_col_q != '0) nx_col = cur_col_q - 1'b1;
				else nb_ok = 1'b0;
			end
			default: begin
				if (cur_row_q != '0) nx_row = cur_row_q - 1'b1;
				else nb_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		cur_col_d = cur_col_q;
		cur_row_d = cur_row_q;
		nb_col_d  = nb_col_q;
		nb_row_d  = nb_row_q;
		dir_d     = dir_q;
		sp_d      = sp_q;
		done_d    = 1'b0;
		found_d   = found_q;
		value_d   = value_q;
		g_we      = 1'b0;
		g_waddr   = gmds_pkg::cell_addr(cur_row_q, cur_col_q);
		g_wdata   = mark;
		g_raddr   = gmds_pkg::cell_addr(in_row, in_col);
		s_we      = 1'b0;
		s_waddr   = sp_m1[gmds_pkg::ADDR_W-1:0];
		s_wdata   = {cur_row_q, cur_col_q, dir_q};
		s_raddr   = sp_m2[gmds_pkg::ADDR_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					found_d = 1'b0;
					value_d = gmds_pkg::C_OPEN;
					cur_col_d = in_col;
					cur_row_d = in_row;
					case (func)
						gmds_pkg::FN_WRITE: begin
							g_we    = in_inside;
							g_waddr = gmds_pkg::cell_addr(in_row, in_col);
							g_wdata = cell_code;
							done_d  = 1'b1;
						end
						gmds_pkg::FN_SOLVE: begin
							if (in_inside && (7'(col) < nc_lim) && (7'(row) < nr_lim))
								state_d = ST_START;
							else
								done_d = 1'b1;
						end
						gmds_pkg::FN_READ: begin
							if (in_inside) state_d = ST_RD;
							else done_d = 1'b1;
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			ST_RD: begin
				value_d = g_rdata;
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_START: begin
				if (g_rdata == gmds_pkg::C_GOAL) begin
					found_d = 1'b1;
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					g_we    = 1'b1;
					dir_d   = '0;
					sp_d    = gmds_pkg::SP_W'(1);
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (dir_q[2]) begin
					// every direction tried: mark dead end and pop
					g_we    = 1'b1;
					g_wdata = gmds_pkg::C_DEAD;
					sp_d    = sp_m1;
					if (sp_m1 == '0) begin
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_POP;
					end
				end else begin
					dir_d    = dir_q + 1'b1;
					nb_col_d = nx_col;
					nb_row_d = nx_row;
					g_raddr  = gmds_pkg::cell_addr(nx_row, nx_col);
					if (nb_ok) state_d = ST_NB;
				end
			end
			ST_NB: begin
				state_d = ST_STEP;
				if (!rd_blocked) begin
					if (g_rdata == gmds_pkg::C_GOAL) begin
						found_d = 1'b1;
						done_d  = 1'b1;
						sp_d    = '0;
						state_d = ST_IDLE;
					end else if (sp_q < gmds_pkg::SP_W'(gmds_pkg::NCELLS)) begin
						g_we      = 1'b1;
						g_waddr   = gmds_pkg::cell_addr(nb_row_q, nb_col_q);
						s_we      = 1'b1;
						cur_col_d = nb_col_q;
						cur_row_d = nb_row_q;
						dir_d     = '0;
						sp_d      = sp_q + 1'b1;
					end
				end
			end
			ST_POP: begin
				{cur_row_d, cur_col_d, dir_d} = s_rdata;
				state_d = ST_STEP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_col_q <= cur_col_d;
		cur_row_q <= cur_row_d;
		nb_col_q  <= nb_col_d;
		nb_row_q  <= nb_row_d;
		dir_q     <= dir_d;
		found_q   <= found_d;
		value_q   <= value_d;
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign found      = found_q;
	assign cell_value = value_q;

endmodule

/* rtl/grid_maze_dfs_solver_core.sv */
// Top level of the grid maze solver: configuration registers and command engine.
//
// Commands are taken when start is high and busy is low; each gives one result beat on done,
// held for a single cycle with no back-pressure. A cell write or an ignored command answers
// in the next cycle without raising busy, and a read passes through the ST_RD state first. A
// solve walks the grid through a single grid memory with a registered read port: each direction
// whose neighbour lies inside the area goes from ST_STEP to ST_NB to read that neighbour, and
// each backtrack from ST_STEP to ST_POP to read the stack. The memories need no clearing pass.
module grid_maze_dfs_solver_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] func,
	input  logic [5:0] col,
	input  logic [5:0] row,
	input  logic [2:0] cell_code,
	output logic       done,
	output logic       found,
	output logic [2:0] cell_value,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [6:0] cfg_data
);

	gmds_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order <= 1'b0;
			cfg_q.ncols <= 7'd64;
			cfg_q.nrows <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gmds_pkg::REG_ORDER: cfg_q.order <= cfg_data[0];
				gmds_pkg::REG_COLS:  cfg_q.ncols <= cfg_data;
				gmds_pkg::REG_ROWS:  cfg_q.nrows <= cfg_data;
				default: ;
			endcase
		end
	end

	gmds_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.col        (col),
		.row        (row),
		.cell_code  (cell_code),
		.cfg        (cfg_q),
		.done       (done),
		.found      (found),
		.cell_value (cell_value)
	);

	// a finished solve or read always leaves with its result beat
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while engine busy");

	a_write_ans: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == gmds_pkg::FN_WRITE) |=> (done && !busy && !found))
		else $error("cell write not answered next cycle");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the grid maze solver: maze loads, cell reads and depth-first solves.
`timescale 1ns / 1ps

module testbench;
	import gmds_pkg::*;

	localparam logic [1:0] FN_NONE = 2'd3;   // unused function code, answers all zero
	localparam int RESET_CYCLES  = 6;
	localparam int RANDOM_ITEMS  = 140;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef enum logic [1:0] {GO_EAST, GO_SOUTH, GO_WEST, GO_NORTH} heading_t;

	typedef struct packed {
		logic [1:0] fn;
		logic [5:0] x;
		logic [5:0] y;
		logic [2:0] code;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] content;
	} answer_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic [1:0] func      = FN_WRITE;
	logic [5:0] col       = '0;
	logic [5:0] row       = '0;
	logic [2:0] cell_code = C_OPEN;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_idx   = REG_ORDER;
	logic [6:0] cfg_data  = '0;
	logic       busy;
	logic       done;
	logic       found;
	logic [2:0] cell_value;

	grid_maze_dfs_solver_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.col        (col),
		.row        (row),
		.cell_code  (cell_code),
		.done       (done),
		.found      (found),
		.cell_value (cell_value),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// maze mirror and search stack of the predictor
	logic [2:0]        model_grid [NCELLS];
	logic [ADDR_W-1:0] stack_spot [NCELLS];
	logic [2:0]        stack_dir  [NCELLS];
	logic              model_order = 1'b0;
	int                model_cols  = MAX_COLS;
	int                model_rows  = MAX_ROWS;

	cmd_t    cmd_queue[$];
	answer_t answer_queue[$];
	cmd_t    on_port;
	logic    presenting;
	int      burst_left = 1;
	int      gap_left   = 0;
	int      mismatches = 0;
	int      cycles     = 0;
	int      issued     = 0;
	int      area_cols  = MAX_COLS;
	int      area_rows  = MAX_ROWS;

	function automatic logic solve_maze(input logic [5:0] x0, input logic [5:0] y0);
		int                nc, nr, sp, cx, cy;
		logic [2:0]        mark, nb, d;
		logic [ADDR_W-1:0] here, nxt;
		heading_t          heading;
		logic              ok;
		nc = (model_cols > MAX_COLS) ? MAX_COLS : model_cols;
		nr = (model_rows > MAX_ROWS) ? MAX_ROWS : model_rows;
		mark = model_order ? C_STAR : C_DOT;
		if (int'(x0) >= nc || int'(y0) >= nr)
			return 1'b0;
		here = {y0, x0};
		if (model_grid[here] == C_GOAL)
			return 1'b1;
		model_grid[here] = mark;
		stack_spot[0] = here;
		stack_dir[0] = 3'd0;
		sp = 1;
		while (sp > 0) begin
			here = stack_spot[sp-1];
			d = stack_dir[sp-1];
			if (d >= 3'd4) begin
				model_grid[here] = C_DEAD;
				sp--;
				continue;
			end
			stack_dir[sp-1] = d + 3'd1;
			cx = int'(here[COL_W-1:0]);
			cy = int'(here[ADDR_W-1:COL_W]);
			// star mode swaps each pair: S,E,N,W
			heading = heading_t'(d[1:0] ^ {1'b0, model_order});
			ok = 1'b1;
			case (heading)
				GO_EAST: begin
					if (cx + 1 < nc) cx++; else ok = 1'b0;
				end
				GO_SOUTH: begin
					if (cy + 1 < nr) cy++; else ok = 1'b0;
				end
				GO_WEST: begin
					if (cx > 0) cx--; else ok = 1'b0;
				end
				default: begin
					if (cy > 0) cy--; else ok = 1'b0;
				end
			endcase
			if (!ok)
				continue;
			nxt = ADDR_W'(cy * MAX_COLS + cx);
			nb = model_grid[nxt];
			if (nb == C_WALL || nb == mark || nb == C_DEAD)
				continue;
			if (nb == C_GOAL)
				return 1'b1;
			if (sp >= NCELLS)
				continue;
			model_grid[nxt] = mark;
			stack_spot[sp] = nxt;
			stack_dir[sp] = 3'd0;
			sp++;
		end
		return 1'b0;
	endfunction

	function automatic answer_t apply_command(input cmd_t c);
		answer_t a;
		a = '0;
		case (c.fn)
			FN_WRITE: model_grid[{c.y, c.x}] = c.code;
			FN_SOLVE: a.hit = solve_maze(c.x, c.y);
			FN_READ:  a.content = model_grid[{c.y, c.x}];
			default:  ;
		endcase
		return a;
	endfunction

	// mostly open and wall, some goals, marks and the two spare codes
	function automatic logic [2:0] pick_code();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) return C_OPEN;
		if (k < 72) return C_WALL;
		if (k < 77) return C_GOAL;
		if (k < 83) return C_DOT;
		if (k < 89) return C_STAR;
		if (k < 94) return C_DEAD;
		if (k < 97) return 3'd6;
		return 3'd7;
	endfunction

	task automatic issue(input logic [1:0] fn, input int x, input int y, input logic [2:0] code);
		cmd_t c;
		c.fn = fn;
		c.x = 6'(x);
		c.y = 6'(y);
		c.code = code;
		cmd_queue.push_back(c);
		issued++;
	endtask

	task automatic settle();
		do @(negedge clk);
		while (cmd_queue.size() != 0 || start || answer_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic ord, input int ncols, input int nrows);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_ORDER;
		cfg_data <= 7'(ord);
		@(posedge clk);
		cfg_idx <= REG_COLS;
		cfg_data <= 7'(ncols);
		@(posedge clk);
		cfg_idx <= REG_ROWS;
		cfg_data <= 7'(nrows);
		@(posedge clk);
		cfg_we <= 1'b0;
		model_order = ord;
		model_cols = ncols;
		model_rows = nrows;
		area_cols = ncols;
		area_rows = nrows;
	endtask

	task automatic flag(input string what, input logic [2:0] want, input logic [2:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
	endtask

	// command driver: bursts of beats with random gaps between them
	always @(posedge clk) begin
		if (arst_n) begin
			presenting = start;
			if (start && !busy) begin
				answer_queue.push_back(apply_command(on_port));
				presenting = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
			if (!presenting) begin
				if (gap_left > 0)
					gap_left--;
				else if (cmd_queue.size() != 0) begin
					on_port = cmd_queue.pop_front();
					presenting = 1'b1;
					func <= on_port.fn;
					col <= on_port.x;
					row <= on_port.y;
					cell_code <= on_port.code;
				end
			end
			start <= presenting;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (answer_queue.size() == 0)
				flag("beat with nothing pending, found", 3'd0, {2'b00, found});
			else begin
				answer_t due;
				due = answer_queue.pop_front();
				if (found !== due.hit)
					flag("found", {2'b00, due.hit}, {2'b00, found});
				if (cell_value !== due.content)
					flag("cell_value", due.content, cell_value);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int phase, ops, k, sx, sy;
		for (int i = 0; i < NCELLS; i++)
			model_grid[i] = C_OPEN;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// full 64x64 area, dot mode: every solve here only touches written cells
		issue(FN_WRITE, 63, 63, C_GOAL);
		issue(FN_SOLVE, 63, 63, C_OPEN);      // goal start
		issue(FN_READ, 63, 63, C_OPEN);
		issue(FN_WRITE, 0, 0, C_WALL);
		issue(FN_WRITE, 1, 0, C_WALL);
		issue(FN_WRITE, 0, 1, C_WALL);
		issue(FN_SOLVE, 0, 0, C_OPEN);        // wall start, boxed in corner -> dead end
		issue(FN_READ, 0, 0, C_OPEN);
		issue(FN_NONE, 63, 0, 3'd7);
		issue(FN_WRITE, 10, 20, 3'd6);
		issue(FN_WRITE, 20, 10, 3'd7);
		issue(FN_READ, 10, 20, C_OPEN);
		issue(FN_READ, 20, 10, C_OPEN);
		issue(FN_WRITE, 30, 30, C_DOT);       // marked start is still searched
		issue(FN_WRITE, 31, 30, C_DEAD);
		issue(FN_WRITE, 30, 31, C_DOT);
		issue(FN_WRITE, 29, 30, C_WALL);
		issue(FN_WRITE, 30, 29, C_GOAL);
		issue(FN_SOLVE, 30, 30, C_OPEN);

		// 2x2 star mode: star blocks, spare code is open, start beyond the area
		set_config(1'b1, 2, 2);
		issue(FN_WRITE, 0, 0, C_OPEN);
		issue(FN_WRITE, 1, 0, 3'd6);
		issue(FN_WRITE, 0, 1, C_STAR);
		issue(FN_WRITE, 1, 1, C_GOAL);
		issue(FN_SOLVE, 0, 0, C_OPEN);
		issue(FN_SOLVE, 2, 0, C_OPEN);
		issue(FN_READ, 1, 0, C_OPEN);

		phase = 0;
		while (issued < RANDOM_ITEMS) begin
			if (phase == 1)
				set_config(1'($urandom_range(0, 1)), MAX_COLS, 1);
			else if (phase == 3)
				set_config(1'($urandom_range(0, 1)), 1, MAX_ROWS);
			else
				set_config(1'($urandom_range(0, 1)), $urandom_range(1, 7),
					$urandom_range(1, 7));
			// fresh maze over the whole active area before anything reads it
			for (int y = 0; y < area_rows; y++)
				for (int x = 0; x < area_cols; x++)
					issue(FN_WRITE, x, y, pick_code());
			ops = $urandom_range(6, 18);
			repeat (ops) begin
				k = $urandom_range(0, 99);
				sx = $urandom_range(0, area_cols - 1);
				sy = $urandom_range(0, area_rows - 1);
				if (k < 40) begin
					if ($urandom_range(0, 9) == 0) begin
						if (area_cols < MAX_COLS) begin
							sx = $urandom_range(area_cols, MAX_COLS - 1);
							sy = $urandom_range(0, MAX_ROWS - 1);
						end else begin
							sx = $urandom_range(0, MAX_COLS - 1);
							sy = $urandom_range(area_rows, MAX_ROWS - 1);
						end
					end
					issue(FN_SOLVE, sx, sy, 3'($urandom_range(0, 7)));
				end else if (k < 65) begin
					issue(FN_READ, sx, sy, 3'($urandom_range(0, 7)));
				end else if (k < 75) begin
					if ($urandom_range(0, 4) == 0) begin
						sx = $urandom_range(0, MAX_COLS - 1);
						sy = $urandom_range(0, MAX_ROWS - 1);
					end
					issue(FN_WRITE, sx, sy, 3'($urandom_range(0, 7)));
				end else if (k < 80) begin
					issue(FN_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
						3'($urandom_range(0, 7)));
				end else begin
					issue(FN_WRITE, sx, sy, C_OPEN);   // clear a mark, reopens paths
				end
			end
			phase++;
		end

		settle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
rtl/gmds_pkg.sv
rtl/gmds_ram.sv
rtl/gmds_ctrl.sv
rtl/grid_maze_dfs_solver_core.sv
bench/testbench.sv
